### sv/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is asserted
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// property checked at every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### sv/hist1d_pkg.sv
// shared constants, types and count arithmetic for the 1d histogram engine
`default_nettype none

package hist1d_pkg;

    localparam int MaxBins    = 1024;
    localparam int CountWidth = 40;
    localparam int NumSlots   = MaxBins + 2;
    localparam int SlotW      = $clog2(NumSlots);
    localparam int NbW        = $clog2(MaxBins + 1);
    localparam int QuoW       = $clog2(MaxBins + 1);
    localparam int DiffW      = 33;
    localparam int ProdW      = NbW + DiffW;

    // fixed field widths of the stream channels
    localparam int ContentW   = 40;
    localparam int SlotOutW   = 11;
    localparam int SampleW    = 32;
    localparam int WeightW    = 16;
    localparam int IndexW     = 12;
    localparam int ValueW     = 40;
    localparam int NumBinsW   = 11;
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 32;

    // request kinds
    localparam logic [1:0] REQ_FILL  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_NUM_BINS    = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_RANGE_LEFT  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_RANGE_RIGHT = 2'd2;

    typedef logic signed [CountWidth-1:0] count_t;

    localparam count_t CntMax = {1'b0, {(CountWidth-1){1'b1}}};
    localparam count_t CntMin = {1'b1, {(CountWidth-1){1'b0}}};

    // operation handed to the bin store
    typedef struct packed {
        logic [1:0]                op;
        logic [SlotW-1:0]          slot;
        logic signed [WeightW-1:0] weight;
        logic signed [ValueW-1:0]  value;
    } store_req_t;

    // completion reported by the bin store
    typedef struct packed {
        logic                       done;
        logic signed [ContentW-1:0] content;
        logic [SlotW-1:0]           slot;
    } store_rsp_t;

    // add a weight to a count, saturating at the count limits
    function automatic count_t sat_add(input count_t v, input logic signed [WeightW-1:0] w);
        logic signed [CountWidth:0] s;
        s = (CountWidth+1)'(v) + (CountWidth+1)'(w);
        if (s[CountWidth] != s[CountWidth-1]) begin
            return s[CountWidth] ? CntMin : CntMax;
        end
        return count_t'(s[CountWidth-1:0]);
    endfunction

    // bring a written value into the count range
    function automatic count_t clamp_count(input logic signed [ValueW-1:0] v);
        logic signed [64:0] ve;
        logic signed [64:0] mx;
        logic signed [64:0] mn;
        ve = 65'(v);
        mx = 65'(CntMax);
        mn = 65'(CntMin);
        if (ve > mx) begin
            return CntMax;
        end
        if (ve < mn) begin
            return CntMin;
        end
        return count_t'(ve[CountWidth-1:0]);
    endfunction

endpackage

`default_nettype wire

### sv/hist1d_binner.sv
// sample to slot mapping: range offset, bin-count multiply, restoring divide
`default_nettype none
`include "assert_macros.svh"

module hist1d_binner (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    start,
    input  logic signed [hist1d_pkg::SampleW-1:0]   sample,
    input  logic signed [hist1d_pkg::SampleW-1:0]   range_left,
    input  logic signed [hist1d_pkg::SampleW-1:0]   range_right,
    input  logic [hist1d_pkg::NbW-1:0]              nb,
    output logic                                    done,
    output logic [hist1d_pkg::SlotW-1:0]            slot
);
    import hist1d_pkg::*;

    localparam int CntW = $clog2(QuoW + 1);

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_MUL   = 2'd1;
    localparam logic [1:0] B_CHECK = 2'd2;
    localparam logic [1:0] B_DIV   = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic signed [DiffW-1:0] diff_reg;
    logic signed [DiffW-1:0] span_reg;
    logic [NbW-1:0]          nb_reg;
    logic [ProdW-1:0]        prod_reg;
    logic [ProdW-1:0]        rem_reg;
    logic [ProdW-1:0]        div_reg;
    logic [QuoW-1:0]         quo_reg;
    logic [CntW-1:0]         cnt_reg;
    logic                    done_reg;
    logic [SlotW-1:0]        slot_reg;

    logic [DiffW-1:0]        diff_abs;
    logic [ProdW-1:0]        span_wide;
    logic                    quo_bit;
    logic [SlotW-1:0]        ovf_slot;

    assign diff_abs  = diff_reg[DiffW-1] ? DiffW'(-diff_reg) : DiffW'(diff_reg);
    assign span_wide = ProdW'(span_reg);
    assign quo_bit   = (rem_reg >= div_reg);
    assign ovf_slot  = SlotW'(nb_reg) + SlotW'(1);

    // sequencer state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (start) begin
                    state_next = B_MUL;
                end
            end
            B_MUL: begin
                state_next = B_CHECK;
            end
            B_CHECK: begin
                if (span_reg > 0 && !diff_reg[DiffW-1] && diff_reg < span_reg) begin
                    state_next = B_DIV;
                end else begin
                    state_next = B_IDLE;
                end
            end
            B_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (state_reg == B_CHECK && state_next == B_IDLE) begin
                done_reg <= 1'b1;
            end
            if (state_reg == B_DIV && cnt_reg == '0) begin
                done_reg <= 1'b1;
            end
        end
    end

    // datapath: offset and span, product, range checks, one quotient bit a cycle
    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                if (start) begin
                    diff_reg <= DiffW'(sample) - DiffW'(range_left);
                    span_reg <= DiffW'(range_right) - DiffW'(range_left);
                    nb_reg   <= nb;
                end
            end
            B_MUL: begin
                prod_reg <= ProdW'(nb_reg) * ProdW'(diff_abs);
            end
            B_CHECK: begin
                rem_reg <= prod_reg;
                div_reg <= span_wide << (QuoW - 1);
                quo_reg <= '0;
                cnt_reg <= CntW'(QuoW - 1);
                if (span_reg <= 0) begin
                    slot_reg <= ovf_slot;
                end else if (diff_reg[DiffW-1]) begin
                    // below the left edge; a quotient above -1 still lands in bin zero
                    slot_reg <= (prod_reg >= span_wide) ? '0 : SlotW'(1);
                end else if (diff_reg >= span_reg) begin
                    slot_reg <= ovf_slot;
                end
            end
            B_DIV: begin
                if (quo_bit) begin
                    rem_reg <= rem_reg - div_reg;
                end
                div_reg <= div_reg >> 1;
                quo_reg <= (quo_reg << 1) | QuoW'(quo_bit);
                cnt_reg <= cnt_reg - CntW'(1);
                if (cnt_reg == '0) begin
                    slot_reg <= SlotW'((quo_reg << 1) | QuoW'(quo_bit)) + SlotW'(1);
                end
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign slot = slot_reg;

    `ASSERT_CLK(a_start_idle, aclk, aresetn, start |-> state_reg == B_IDLE,
        "binner started while busy")
    `ASSERT_CLK(a_slot_range, aclk, aresetn, done_reg |-> slot_reg <= ovf_slot,
        "binner slot beyond overflow")
    `ASSERT_CLK(a_div_bound, aclk, aresetn,
        state_reg == B_DIV |-> rem_reg < (div_reg << 1),
        "divider remainder out of bound")

endmodule

`default_nettype wire

### sv/hist1d_store.sv
// bin count memory with read-modify-write and a clearing sweep
`default_nettype none
`include "assert_macros.svh"

module hist1d_store (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  hist1d_pkg::store_req_t  req,
    output logic                    ready,
    output hist1d_pkg::store_rsp_t  rsp
);
    import hist1d_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MOD   = 2'd1;
    localparam logic [1:0] S_CLEAR = 2'd2;

    logic [1:0]               state_reg;
    logic [1:0]               op_reg;
    logic [SlotW-1:0]         slot_reg;
    logic signed [WeightW-1:0] weight_reg;
    logic signed [ValueW-1:0] value_reg;
    logic [SlotW-1:0]         clr_addr_reg;
    logic                     report_reg;

    count_t                   mem [NumSlots];
    count_t                   rd_data_reg;

    logic                     mem_we;
    logic [SlotW-1:0]         mem_waddr;
    count_t                   mem_wdata;
    count_t                   new_val;
    logic                     clr_last;

    assign clr_last = (clr_addr_reg == SlotW'(NumSlots - 1));
    assign ready    = (state_reg == S_IDLE);

    // new content for the slot read in the previous cycle
    always_comb begin
        case (op_reg)
            REQ_FILL:  new_val = sat_add(rd_data_reg, weight_reg);
            REQ_WRITE: new_val = clamp_count(value_reg);
            default:   new_val = rd_data_reg;
        endcase
    end

    // write port: sweep zeros or write back the modified count
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = new_val;
        case (state_reg)
            S_MOD: begin
                mem_we = (op_reg == REQ_FILL) || (op_reg == REQ_WRITE);
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            default: ;
        endcase
    end

    // one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[req.slot];
    end

    // operation sequencing, reset starts with a sweep that reports nothing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            report_reg   <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        if (req.op == REQ_CLEAR) begin
                            state_reg    <= S_CLEAR;
                            clr_addr_reg <= '0;
                            report_reg   <= 1'b1;
                        end else begin
                            state_reg <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    state_reg <= S_IDLE;
                end
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + SlotW'(1);
                    if (clr_last) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // request payload
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && start) begin
            op_reg     <= req.op;
            slot_reg   <= req.slot;
            weight_reg <= req.weight;
            value_reg  <= req.value;
        end
    end

    // completion
    always_comb begin
        rsp.done    = (state_reg == S_MOD) || (state_reg == S_CLEAR && clr_last && report_reg);
        rsp.content = (state_reg == S_MOD) ? ContentW'(new_val) : '0;
        rsp.slot    = (state_reg == S_MOD) ? slot_reg : '0;
    end

    `ASSERT_CLK(a_start_ready, aclk, aresetn, start |-> state_reg == S_IDLE,
        "store started while busy")
    `ASSERT_CLK(a_done_idle, aclk, aresetn, rsp.done |=> state_reg == S_IDLE,
        "store not idle after completion")
    `ASSERT_ALWAYS(a_clr_range, aclk,
        state_reg == S_CLEAR |-> clr_addr_reg < SlotW'(NumSlots),
        "clear sweep address past the last slot")

endmodule

`default_nettype wire

### sv/histogram_1d_engine.sv
// 1d histogram engine: fills, reads, writes and clears a bin count store
//
// Input channel s_*: one request per transaction, the kind in s_tuser (fill,
// read bin, write bin, clear all). Output channel m_*: exactly one result
// per request, in request order, holding the slot touched and its content.
// Configuration channel cfg_*: register writes (bin count, left and right
// range edges), always accepted; write only while no request is in flight.
// Requests are handled one at a time. A fill first passes through the
// 11-step restoring divider that maps the sample offset to a bin (skipped
// when the sample falls outside the range), then a read and a write back;
// a read is one memory read, a write a memory read and a write back; a clear
// sweeps the store at one memory row per cycle. The next request can be
// accepted in the same cycle as its predecessor's result appears.
// The result sits in an output register, so the next request is accepted
// while a result waits; a request reaches the store only once that register
// is empty, so a stalled receiver holds the engine after one request.
// After reset the store sweeps all 1026 slots to zero with s_tready low;
// configuration writes are taken during the sweep.
`default_nettype none

module histogram_1d_engine (
    input  logic         aclk,
    input  logic         aresetn,
    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // sample[31:0], weight[47:32], bin_index[59:48],
                                    // write_value[99:60], zero[103:100]
    input  logic [1:0]   s_tuser,   // req_type[1:0]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [55:0]  m_tdata,   // content[39:0], slot[50:40], zero[55:51]
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import hist1d_pkg::*;

    localparam logic [1:0] T_IDLE  = 2'd0;
    localparam logic [1:0] T_BIN   = 2'd1;
    localparam logic [1:0] T_ISSUE = 2'd2;
    localparam logic [1:0] T_WAIT  = 2'd3;

    logic [1:0]                 state_reg;
    logic [NumBinsW-1:0]        num_bins_reg;
    logic signed [SampleW-1:0]  range_left_reg;
    logic signed [SampleW-1:0]  range_right_reg;
    store_req_t                 req_reg;
    logic                       m_tvalid_reg;
    logic signed [ContentW-1:0] m_content_reg;
    logic [SlotOutW-1:0]        m_slot_reg;

    logic [1:0]                 s_req_type;
    logic signed [SampleW-1:0]  s_sample;
    logic signed [WeightW-1:0]  s_weight;
    logic signed [IndexW-1:0]   s_bin_index;
    logic signed [ValueW-1:0]   s_write_value;

    logic [NbW-1:0]             nb_eff;
    logic signed [31:0]         idx_ext;
    logic [SlotW-1:0]           idx_slot;
    logic                       s_accept;
    logic                       bin_start;
    logic                       bin_done;
    logic [SlotW-1:0]           bin_slot;
    logic                       store_start;
    logic                       store_ready;
    store_rsp_t                 store_rsp;

    // unpack the request
    assign s_req_type    = s_tuser;
    assign s_sample      = s_tdata[31:0];
    assign s_weight      = s_tdata[47:32];
    assign s_bin_index   = s_tdata[59:48];
    assign s_write_value = s_tdata[99:60];

    assign s_tready  = (state_reg == T_IDLE) && store_ready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // bin count in use, brought into 1..MaxBins
    always_comb begin
        if (num_bins_reg == '0) begin
            nb_eff = NbW'(1);
        end else if (32'(num_bins_reg) > MaxBins) begin
            nb_eff = NbW'(MaxBins);
        end else begin
            nb_eff = NbW'(num_bins_reg);
        end
    end

    // slot addressed by a bin index
    assign idx_ext = 32'(s_bin_index);
    always_comb begin
        if (idx_ext < 0) begin
            idx_slot = '0;
        end else if (idx_ext >= $signed(32'(nb_eff))) begin
            idx_slot = SlotW'(nb_eff) + SlotW'(1);
        end else begin
            idx_slot = SlotW'(idx_ext) + SlotW'(1);
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_bins_reg    <= NumBinsW'(MaxBins);
            range_left_reg  <= '0;
            range_right_reg <= 32'sd1024;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_NUM_BINS:    num_bins_reg    <= cfg_data[NumBinsW-1:0];
                CFG_RANGE_LEFT:  range_left_reg  <= cfg_data;
                CFG_RANGE_RIGHT: range_right_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign bin_start   = s_accept && (s_req_type == REQ_FILL);
    assign store_start = (state_reg == T_ISSUE) && !m_tvalid_reg;

    // request sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
        end else begin
            case (state_reg)
                T_IDLE: begin
                    if (s_accept) begin
                        state_reg <= (s_req_type == REQ_FILL) ? T_BIN : T_ISSUE;
                    end
                end
                T_BIN: begin
                    if (bin_done) begin
                        state_reg <= T_ISSUE;
                    end
                end
                T_ISSUE: begin
                    if (store_start) begin
                        state_reg <= T_WAIT;
                    end
                end
                T_WAIT: begin
                    if (store_rsp.done) begin
                        state_reg <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    // request payload, slot filled in by the binner for fills
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg.op     <= s_req_type;
            req_reg.slot   <= idx_slot;
            req_reg.weight <= s_weight;
            req_reg.value  <= s_write_value;
        end else if (state_reg == T_BIN && bin_done) begin
            req_reg.slot <= bin_slot;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == T_WAIT && store_rsp.done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == T_WAIT && store_rsp.done) begin
            m_content_reg <= store_rsp.content;
            m_slot_reg    <= SlotOutW'(store_rsp.slot);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_slot_reg, m_content_reg};

    hist1d_binner u_binner (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (bin_start),
        .sample      (s_sample),
        .range_left  (range_left_reg),
        .range_right (range_right_reg),
        .nb          (nb_eff),
        .done        (bin_done),
        .slot        (bin_slot)
    );

    hist1d_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (store_start),
        .req     (req_reg),
        .ready   (store_ready),
        .rsp     (store_rsp)
    );

endmodule

`default_nettype wire

### tb/tb_histogram_1d_engine.sv
// self-checking testbench for the 1d histogram engine, directed table then random phases
`timescale 1ns / 100ps

module tb_histogram_1d_engine;
    import hist1d_pkg::*;

    localparam int NumDirected   = 36;
    localparam int NumPhases     = 7;
    localparam int PhaseItems    = 275;
    localparam int HoldOffCycles = 400;
    localparam int DrainCycles   = 60;
    localparam int CycleLimit    = 1000000;

    localparam logic signed [31:0] SmpMin    = 32'sh8000_0000;
    localparam logic signed [31:0] SmpMax    = 32'sh7FFF_FFFF;
    localparam count_t              PatternA = 40'sh55_5555_5555;
    localparam count_t              PatternB = 40'shAA_AAAA_AAAA;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    // one request or one register write; op holds the request kind or the register index
    typedef struct {
        row_kind_t                 kind;
        logic [1:0]                op;
        logic signed [31:0]        arg;
        logic signed [15:0]        weight;
        logic signed [11:0]        index;
        count_t                    value;
        bit                        pinned;
        count_t                    exp_content;
        logic [SlotOutW-1:0]       exp_slot;
    } stim_row_t;

    typedef struct {
        count_t              content;
        logic [SlotOutW-1:0] slot;
    } bin_result_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    wire          s_tready;
    logic [103:0] s_tdata   = '0;   // sample[31:0], weight[47:32], bin_index[59:48],
                                    // write_value[99:60], zero[103:100]
    logic [1:0]   s_tuser   = '0;   // req_type[1:0]
    wire          m_tvalid;
    logic         m_tready  = 1'b0;
    wire  [55:0]  m_tdata;          // content[39:0], slot[50:40], zero[55:51]
    logic         cfg_valid = 1'b0;
    wire          cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_data  = '0;

    // predicted engine state
    count_t             bin_counts [NumSlots] = '{default: '0};
    logic [10:0]        cur_num_bins = 11'd1024;
    logic signed [31:0] cur_left     = 32'sd0;
    logic signed [31:0] cur_right    = 32'sd1024;

    bin_result_t pending_results [$];
    int          error_count      = 0;
    int          cycle_count      = 0;
    bit          no_gaps          = 1'b0;
    bit          hold_off_request = 1'b0;
    bit          hold_off_done    = 1'b0;

    // directed rows: kind, op, sample or register data, weight, index, value, pinned, content, slot
    stim_row_t directed_rows [NumDirected] = '{
        // empty store after reset, index extremes
        '{ROW_REQ, REQ_READ,  0, 0, -1,    0, 1, 0, 0},
        '{ROW_REQ, REQ_READ,  0, 0, 1024,  0, 1, 0, 1025},
        '{ROW_REQ, REQ_READ,  0, 0, 2047,  0, 1, 0, 1025},
        '{ROW_REQ, REQ_READ,  0, 0, -2048, 0, 1, 0, 0},
        // fills at the range edges and the sample extremes
        '{ROW_REQ, REQ_FILL,  0,      1,        0, 0, 1, 1,      1},
        '{ROW_REQ, REQ_FILL,  -1,     32767,    0, 0, 1, 32767,  0},
        '{ROW_REQ, REQ_FILL,  SmpMax, -32768,   0, 0, 1, -32768, 1025},
        '{ROW_REQ, REQ_FILL,  SmpMin, 5,        0, 0, 0, 0,      0},
        '{ROW_REQ, REQ_FILL,  1023,   16'hFFFF, 0, 0, 0, 0,      0},
        // writes at the count limits, then fills that saturate
        '{ROW_REQ, REQ_WRITE, 0, 0,      5,    CntMax,   1, CntMax, 6},
        '{ROW_REQ, REQ_FILL,  5, 32767,  0,    0,        1, CntMax, 6},
        '{ROW_REQ, REQ_WRITE, 0, 0,      7,    CntMin,   1, CntMin, 8},
        '{ROW_REQ, REQ_FILL,  7, -32768, 0,    0,        1, CntMin, 8},
        '{ROW_REQ, REQ_WRITE, 0, 0,      -1,   PatternA, 0, 0,      0},
        '{ROW_REQ, REQ_WRITE, 0, 0,      1024, PatternB, 0, 0,      0},
        '{ROW_REQ, REQ_READ,  0, 0,      0,    0,        0, 0,      0},
        '{ROW_REQ, REQ_CLEAR, 0, 0,      0,    0,        1, 0,      0},
        '{ROW_REQ, REQ_READ,  0, 0,      5,    0,        1, 0,      6},
        // zero bin count acts as one; sample just below the left edge
        '{ROW_CFG, CFG_NUM_BINS,    0,   0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_RANGE_LEFT,  -10, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_RANGE_RIGHT, 10,  0, 0, 0, 0, 0, 0},
        '{ROW_REQ, REQ_FILL,  -11, 2, 0, 0, 0, 0, 0},
        '{ROW_REQ, REQ_FILL,  10,  1, 0, 0, 0, 0, 0},
        '{ROW_REQ, REQ_READ,  0,   0, 1, 0, 0, 0, 0},
        // oversized bin count, reversed range
        '{ROW_CFG, CFG_NUM_BINS,    2047,   0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_RANGE_LEFT,  SmpMax, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_RANGE_RIGHT, SmpMin, 0, 0, 0, 0, 0, 0},
        '{ROW_REQ, REQ_FILL,  0, 3, 0, 0, 0, 0, 0},
        // full 32-bit range
        '{ROW_CFG, CFG_NUM_BINS,    1024,   0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_RANGE_LEFT,  SmpMin, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_RANGE_RIGHT, SmpMax, 0, 0, 0, 0, 0, 0},
        '{ROW_REQ, REQ_FILL,  32'sh7FFF_FFFE, 9, 0, 0, 0, 0, 0},
        '{ROW_REQ, REQ_FILL,  SmpMax,         8, 0, 0, 0, 0, 0},
        // empty range
        '{ROW_CFG, CFG_RANGE_LEFT,  5, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_RANGE_RIGHT, 5, 0, 0, 0, 0, 0, 0},
        '{ROW_REQ, REQ_FILL,  5, 4, 0, 0, 0, 0, 0}
    };

    histogram_1d_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic count_t limit_count(input longint v);
        if (v > longint'(CntMax)) begin
            return CntMax;
        end
        if (v < longint'(CntMin)) begin
            return CntMin;
        end
        return count_t'(v);
    endfunction

    function automatic longint slot_for_index(input logic signed [11:0] idx, input longint nb);
        if (idx < 0) begin
            return 0;
        end
        if (longint'(idx) >= nb) begin
            return nb + 1;
        end
        return longint'(idx) + 1;
    endfunction

    // apply one request to the predicted store and return the slot and content it reports
    function automatic bin_result_t predict_request(input stim_row_t row);
        longint      nb;
        longint      span;
        longint      quo;
        longint      slot;
        bin_result_t res;
        nb = longint'(cur_num_bins);
        if (nb == 0) begin
            nb = 1;
        end
        if (nb > MaxBins) begin
            nb = MaxBins;
        end
        slot = 0;
        case (row.op)
            REQ_FILL: begin
                if (cur_right <= cur_left) begin
                    slot = nb + 1;
                end else begin
                    span = longint'(cur_right) - longint'(cur_left);
                    quo  = nb * (longint'(row.arg) - longint'(cur_left)) / span;
                    if (quo < 0) begin
                        slot = 0;
                    end else if (quo >= nb) begin
                        slot = nb + 1;
                    end else begin
                        slot = quo + 1;
                    end
                end
                bin_counts[slot] = limit_count(longint'(bin_counts[slot]) + longint'(row.weight));
            end
            REQ_READ: begin
                slot = slot_for_index(row.index, nb);
            end
            REQ_WRITE: begin
                slot = slot_for_index(row.index, nb);
                bin_counts[slot] = limit_count(longint'(row.value));
            end
            REQ_CLEAR: begin
                foreach (bin_counts[i]) begin
                    bin_counts[i] = '0;
                end
            end
            default: ;
        endcase
        res.slot    = SlotOutW'(slot);
        res.content = bin_counts[slot];
        return res;
    endfunction

    // uniform pick in [lo, hi]
    function automatic longint pick_between(input longint lo, input longint hi);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return lo + longint'(r % 64'(hi - lo + 1));
    endfunction

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // drop the request valid and let every outstanding result come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // cfg_valid stays up here and is lowered by the next request
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_NUM_BINS:    cur_num_bins = data[10:0];
            CFG_RANGE_LEFT:  cur_left     = data;
            CFG_RANGE_RIGHT: cur_right    = data;
            default: ;
        endcase
    endtask

    // offer one request, wait for the transaction, queue its expected result
    task automatic issue_request(input stim_row_t row);
        bin_result_t predicted;
        cfg_valid <= 1'b0;
        if (!no_gaps && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.op;
        s_tdata  <= {4'b0, row.value, row.index, row.weight, row.arg};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = predict_request(row);
        if (row.pinned) begin
            predicted.content = row.exp_content;
            predicted.slot    = row.exp_slot;
        end
        pending_results.push_back(predicted);
    endtask

    // stimulus
    initial begin
        stim_row_t   row;
        longint      span;
        longint      margin;
        longint      lo;
        longint      hi;
        logic [10:0] nb_pick;
        int          pick;
        int          nb_eff;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(directed_rows[i].op, directed_rows[i].arg);
            end else begin
                issue_request(directed_rows[i]);
            end
        end

        for (int phase = 0; phase < NumPhases; phase++) begin
            wait_idle();
            no_gaps = (phase == 3);
            case (phase)
                0: begin
                    write_reg(CFG_NUM_BINS, 32'd1024);
                    write_reg(CFG_RANGE_LEFT, 32'd0);
                    write_reg(CFG_RANGE_RIGHT, 32'd1024);
                end
                1: begin
                    write_reg(CFG_NUM_BINS, 32'd16);
                    write_reg(CFG_RANGE_LEFT, -32'sd1000);
                    write_reg(CFG_RANGE_RIGHT, 32'sd3000);
                end
                2: begin
                    write_reg(CFG_NUM_BINS, 32'd1);
                    write_reg(CFG_RANGE_LEFT, SmpMin);
                    write_reg(CFG_RANGE_RIGHT, SmpMax);
                end
                3: begin
                    write_reg(CFG_NUM_BINS, 32'd1024);
                    write_reg(CFG_RANGE_LEFT, SmpMin);
                    write_reg(CFG_RANGE_RIGHT, SmpMax);
                end
                4: begin
                    // random setting, bin count possibly zero or oversized
                    pick = $urandom_range(2);
                    if (pick == 0) begin
                        nb_pick = '0;
                    end else if (pick == 1) begin
                        nb_pick = 11'($urandom_range(2047, 1025));
                    end else begin
                        nb_pick = 11'($urandom_range(1024, 1));
                    end
                    write_reg(CFG_NUM_BINS, {21'($urandom), nb_pick});
                    write_reg(CFG_RANGE_LEFT, $urandom);
                    write_reg(CFG_RANGE_RIGHT, $urandom);
                end
                5: begin
                    write_reg(CFG_NUM_BINS, 32'd1000);
                    write_reg(CFG_RANGE_LEFT, -32'sd50);
                    write_reg(CFG_RANGE_RIGHT, 32'sd50);
                end
                default: begin
                    write_reg(CFG_NUM_BINS, 32'd3);
                    write_reg(CFG_RANGE_LEFT, 32'sd100);
                    write_reg(CFG_RANGE_RIGHT, 32'sd40);
                end
            endcase

            nb_eff = int'(cur_num_bins);
            if (nb_eff == 0) begin
                nb_eff = 1;
            end
            if (nb_eff > MaxBins) begin
                nb_eff = MaxBins;
            end

            for (int item = 0; item < PhaseItems; item++) begin
                row.kind        = ROW_REQ;
                row.pinned      = 1'b0;
                row.exp_content = '0;
                row.exp_slot    = '0;

                // mostly fills, clears kept rare since each sweeps the whole store
                pick = $urandom_range(999);
                if (pick < 15) begin
                    row.op = REQ_CLEAR;
                end else if (pick < 600) begin
                    row.op = REQ_FILL;
                end else if (pick < 800) begin
                    row.op = REQ_READ;
                end else begin
                    row.op = REQ_WRITE;
                end

                // sample: around the range, at either edge, or anywhere
                span   = longint'(cur_right) - longint'(cur_left);
                margin = ((span > 0) ? span / 8 : 0) + 3;
                pick   = $urandom_range(9);
                if (pick == 8) begin
                    lo = longint'(cur_left) - 3;
                    hi = longint'(cur_left) + 3;
                end else if (pick == 9) begin
                    lo = longint'(cur_right) - 3;
                    hi = longint'(cur_right) + 3;
                end else begin
                    lo = longint'(cur_left) - margin;
                    hi = longint'(cur_right) + margin;
                end
                if (lo < longint'(SmpMin)) begin
                    lo = SmpMin;
                end
                if (hi > longint'(SmpMax)) begin
                    hi = SmpMax;
                end
                if (pick == 7 || hi < lo) begin
                    row.arg = $urandom;
                end else begin
                    row.arg = 32'(pick_between(lo, hi));
                end

                row.weight = 16'($urandom);

                // index: in use range with both out-of-range neighbors, or any 12-bit value
                if ($urandom_range(9) < 8) begin
                    row.index = 12'(int'($urandom_range(nb_eff + 1)) - 1);
                end else begin
                    row.index = 12'($urandom);
                end

                case ($urandom_range(3))
                    0:       row.value = count_t'({$urandom, $urandom});
                    1:       row.value = CntMax - count_t'($urandom_range(40000));
                    2:       row.value = CntMin + count_t'($urandom_range(40000));
                    default: row.value = count_t'($urandom_range(1000));
                endcase

                if (phase == 1 && item == 100) begin
                    hold_off_request = 1'b1;
                end
                issue_request(row);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_histogram_1d_engine: done, clean");
        end else begin
            $display("tb_histogram_1d_engine: done, errors");
        end
        $finish;
    end

    // result receiver: random stalls, one long hold-off to back up the engine
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_request && !hold_off_done) begin
                m_tready      <= 1'b0;
                hold_off_done  = 1'b1;
                repeat (HoldOffCycles) @(posedge aclk);
            end else begin
                m_tready <= no_gaps || ($urandom_range(99) >= 33);
            end
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        bin_result_t         want;
        count_t              got_content;
        logic [SlotOutW-1:0] got_slot;
        if (aresetn && m_tvalid && m_tready) begin
            got_content = m_tdata[39:0];
            got_slot    = m_tdata[50:40];
            if (pending_results.size() == 0) begin
                flag_error($sformatf("unexpected result: content %0d slot %0d",
                                     got_content, got_slot));
            end else begin
                want = pending_results.pop_front();
                if (got_content != want.content) begin
                    flag_error($sformatf("content mismatch at slot %0d: expected %0d got %0d",
                                         want.slot, want.content, got_content));
                end
                if (got_slot != want.slot) begin
                    flag_error($sformatf("slot mismatch: expected %0d got %0d",
                                         want.slot, got_slot));
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CycleLimit) begin
            $display("tb_histogram_1d_engine: done, errors");
            $finish;
        end
    end

endmodule

### files.f
+incdir+sv
sv/hist1d_pkg.sv
sv/hist1d_binner.sv
sv/hist1d_store.sv
sv/histogram_1d_engine.sv
tb/tb_histogram_1d_engine.sv
